@@ rtl/core/rqs_pkg.sv @@
`default_nettype none

package rqs_pkg;

  localparam int PTR_W  = 4;
  localparam int DEPTH  = 1 << PTR_W;
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 3;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  // command codes on the input stream
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ASSIGN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd5;

  typedef enum logic [1:0] {
    MODE_QUEUE    = 2'd0,
    MODE_STACK    = 2'd1,
    MODE_FALLBACK = 2'd2,
    MODE_ARRAY    = 2'd3
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_MODE  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_PULL,
    OP_POP,
    OP_GET,
    OP_ASSIGN,
    OP_FILL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] word;
    logic [PTR_W-1:0]  index;
  } cmd_entry_t;

  // entries held for a given head and tail
  function automatic logic [CNT_W-1:0] rqs_held(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] t);
    logic [CNT_W-1:0] hx;
    hx = {1'b0, h};
    if (hx <= t) return t - hx;
    return t + CNT_W'(DEPTH) - hx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ring_queue_stack_store.sv @@
// Ring store of 16 words of 32 bits with head and tail pointers, run as a
// queue, a stack, a fallback queue (last entry kept) or a fixed array,
// picked by the 2-bit mode register; each command on the input stream gives
// exactly one result on the output stream. A front stage decodes commands
// into a two-entry queue, and a back stage executes one command per cycle,
// unless the result stream stalls, against the store and loads a result
// register, so the block takes one item per clock while not stalled, and
// fill in array mode writes all entries in the cycle it executes. Entry
// valid bits are flops cleared by reset. Mode writes reset the pointers
// and keep the entries; they are meant only while no command is in flight.
`default_nettype none

module ring_queue_stack_store
  import rqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // config write channel: mode (0 queue, 1 stack, 2 fallback, 3 array)
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_data,
  // input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // command[2:0], data_in[34:3], index[38:35], zero pad[39]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // data_out[31:0], status[34:32], fill_count[39:35]
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic       q_full;
  logic       q_push;
  cmd_entry_t q_wr_entry;
  logic       q_pop;
  logic       q_valid;
  cmd_entry_t q_rd_entry;

  // config is always taken; the write goes to the mode register
  assign cfg_ready = 1'b1;

  // front: decode and queue the command
  rqs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_wr_entry)
  );

  // decouples the input transfer from result backpressure
  rqs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rd_entry (q_rd_entry)
  );

  // back: pointers, entry store, mode register and result register
  rqs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_entry       (q_rd_entry),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/rqs_front.sv @@
`default_nettype none

module rqs_front
  import rqs_pkg::*;
(
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_entry_t            q_entry
);

  logic [CMD_W-1:0] cmd;

  assign cmd           = s_axis_tdata[CMD_W-1:0];
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_entry.word  = s_axis_tdata[CMD_W +: DATA_W];
    q_entry.index = s_axis_tdata[CMD_W+DATA_W +: PTR_W];
    case (cmd)
      CMD_PUSH:   q_entry.op = OP_PUSH;
      CMD_PULL:   q_entry.op = OP_PULL;
      CMD_POP:    q_entry.op = OP_POP;
      CMD_GET:    q_entry.op = OP_GET;
      CMD_ASSIGN: q_entry.op = OP_ASSIGN;
      CMD_FILL:   q_entry.op = OP_FILL;
      default:    q_entry.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rqs_fifo.sv @@
`default_nettype none

module rqs_fifo
  import rqs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire cmd_entry_t wr_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            valid,
  output cmd_entry_t      rd_entry
);

  cmd_entry_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign valid    = count != 2'd0;
  assign rd_entry = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_entry;
  end

endmodule

`default_nettype wire

@@ rtl/core/rqs_back.sv @@
`default_nettype none

module rqs_back
  import rqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_data,
  input  wire logic             q_valid,
  input  wire cmd_entry_t       q_entry,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic [DATA_W-1:0] slot_data [DEPTH];
  logic [DEPTH-1:0]  slot_valid;
  logic [DEPTH-1:0]  slot_valid_next;
  mode_t             mode;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [CNT_W-1:0]  tail;
  logic [CNT_W-1:0]  tail_next;

  logic              exec;
  logic [CNT_W-1:0]  held_cur;
  logic              empty;
  logic [CNT_W-1:0]  tail_dec;
  logic [PTR_W-1:0]  rd_pos;
  logic              rd_valid;
  logic [DATA_W-1:0] rd_word;
  logic              wr_en;
  logic              wr_clr;
  logic [PTR_W-1:0]  wr_pos;
  logic              fill_all;
  status_t           st;
  logic [DATA_W-1:0] dout;
  logic [CNT_W-1:0]  cnt_next;

  assign exec     = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop    = exec;
  assign held_cur = rqs_held(head, tail);
  assign empty    = tail == {1'b0, head};
  assign tail_dec = (tail == '0) ? CNT_W'(DEPTH - 1) : tail - 1'b1;

  always_comb begin
    case (q_entry.op)
      OP_PULL: rd_pos = (mode == MODE_STACK) ? tail_dec[PTR_W-1:0] : head;
      OP_GET:  rd_pos = head + q_entry.index;
      default: rd_pos = head;
    endcase
  end

  // invalid entries read as zero
  assign rd_valid = slot_valid[rd_pos];
  assign rd_word  = rd_valid ? slot_data[rd_pos] : '0;

  always_comb begin
    head_next = head;
    tail_next = tail;
    wr_en     = 1'b0;
    wr_clr    = 1'b0;
    wr_pos    = tail[PTR_W-1:0];
    fill_all  = 1'b0;
    st        = ST_OK;
    dout      = '0;
    case (q_entry.op)
      OP_PUSH: begin
        if (mode == MODE_ARRAY) begin
          st = ST_MODE;
        end else if (held_cur >= CNT_W'(DEPTH - 1)) begin
          st = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_pos    = tail[PTR_W-1:0];
          tail_next = {1'b0, tail[PTR_W-1:0] + 1'b1};
        end
      end
      OP_PULL: begin
        if (mode == MODE_ARRAY) begin
          st = ST_MODE;
        end else if (empty) begin
          st = ST_EMPTY;
        end else begin
          st   = rd_valid ? ST_OK : ST_EMPTY;
          dout = rd_word;
          if (mode == MODE_STACK) begin
            tail_next = tail_dec;
            wr_en     = 1'b1;
            wr_clr    = 1'b1;
            wr_pos    = tail_dec[PTR_W-1:0];
          end else if (!(mode == MODE_FALLBACK && held_cur == CNT_W'(1))) begin
            head_next = head + 1'b1;
            wr_en     = 1'b1;
            wr_clr    = 1'b1;
            wr_pos    = head;
          end
        end
      end
      OP_POP: begin
        if (mode == MODE_ARRAY) begin
          st = ST_MODE;
        end else if (empty) begin
          st = ST_EMPTY;
        end else if (mode == MODE_STACK) begin
          tail_next = tail_dec;
          wr_en     = 1'b1;
          wr_clr    = 1'b1;
          wr_pos    = tail_dec[PTR_W-1:0];
        end else if (!(mode == MODE_FALLBACK && held_cur == CNT_W'(1))) begin
          head_next = head + 1'b1;
          wr_en     = 1'b1;
          wr_clr    = 1'b1;
          wr_pos    = head;
        end
      end
      OP_GET: begin
        if (held_cur == '0) begin
          st = ST_EMPTY;
        end else if ({1'b0, q_entry.index} >= held_cur) begin
          st = ST_RANGE;
        end else begin
          st   = rd_valid ? ST_OK : ST_EMPTY;
          dout = rd_word;
        end
      end
      OP_ASSIGN: begin
        // a 4-bit index never reaches the depth, so no range error here
        if (mode != MODE_ARRAY) begin
          st = ST_MODE;
        end else begin
          wr_en  = 1'b1;
          wr_pos = head + q_entry.index;
        end
      end
      OP_FILL: begin
        head_next = '0;
        case (mode)
          MODE_ARRAY: begin
            tail_next = CNT_W'(DEPTH);
            fill_all  = 1'b1;
          end
          MODE_FALLBACK: begin
            tail_next = CNT_W'(1);
            wr_en     = 1'b1;
            wr_pos    = '0;
          end
          default: tail_next = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign cnt_next = rqs_held(head_next, tail_next);

  always_comb begin
    slot_valid_next = slot_valid;
    if (exec) begin
      if (fill_all) slot_valid_next = '1;
      else if (wr_en) slot_valid_next[wr_pos] = !wr_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      mode          <= MODE_QUEUE;
      head          <= '0;
      tail          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
      if (cfg_we) begin
        mode <= mode_t'(cfg_data);
        head <= '0;
        tail <= (mode_t'(cfg_data) == MODE_ARRAY) ? CNT_W'(DEPTH) : '0;
      end else if (exec) begin
        head <= head_next;
        tail <= tail_next;
      end
      if (exec) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      m_axis_tdata <= {cnt_next, st, dout};
      if (fill_all) begin
        for (int i = 0; i < DEPTH; i++) slot_data[i] <= q_entry.word;
      end else if (wr_en) begin
        slot_data[wr_pos] <= wr_clr ? '0 : q_entry.word;
      end
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_cur <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_tail_depth_array: assert property (@(posedge clk) disable iff (rst)
    tail == CNT_W'(DEPTH) |-> mode == MODE_ARRAY)
    else $error("tail at depth outside array mode");

  a_array_head: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ARRAY |-> head == '0)
    else $error("head moved in array mode");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[DATA_W +: ST_W] == ST_FULL
    |-> m_axis_tdata[DATA_W+ST_W +: CNT_W] >= CNT_W'(DEPTH - 1))
    else $error("full reported below full count");
`endif

endmodule

`default_nettype wire
